[src/stwm_pkg.sv]
package stwm_pkg;

    // Elements held per run
    localparam int unsigned DEPTH = 32;
    // Address and count widths of one run
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    // Width of one element
    localparam int unsigned DW    = 32;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [DW-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] value_res;
        logic                 last;
        logic                 overflow;
    } t_res_item;

endpackage

[src/stwm_ram.sv]
module stwm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents before a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sorted_two_way_merge.sv]
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+--------------------------
// item     | in        | start high while busy low     | i_item (op, value)
// result   | out       | o_res_valid, one cycle each   | o_res (value_res, last,
//          |           |                               |        overflow)
//
// A load (op 0 or 1) leaves busy low, so loads stream one per clock.
// A run with N loaded elements holds busy high until its N results are picked and shows one
// result per cycle, each registered in the cycle after it is picked; both run memories are read once per
// cycle, and the read of each run's entry 0 is registered as the run starts merging.
// A run with nothing loaded leaves busy low and shows nothing.
// Reset clears the counts, the dropped flag and the sequencer; run contents are not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
module sorted_two_way_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  stwm_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output stwm_pkg::t_res_item o_res
);

    import stwm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state          r_state,     n_state;
    logic [CW-1:0]   r_cnt_a,     n_cnt_a;
    logic [CW-1:0]   r_cnt_b,     n_cnt_b;
    logic            r_drop,      n_drop;
    logic [CW-1:0]   r_ia,        n_ia;
    logic [CW-1:0]   r_ib,        n_ib;
    logic            r_res_valid, n_res_valid;
    t_res_item       r_res,       n_res;

    logic            accept;
    logic            we_a, we_b;
    logic [DW-1:0]   rd_a, rd_b;
    logic            has_a, has_b, take_a, is_last;
    logic [DW-1:0]   pick;
    logic [CW:0]     total, taken;

    // Run memories: written at the fill count, read at the next head pointer so the
    // registered read data is the current head of each run while merging.
    stwm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_item.value),
        .i_raddr (n_ia[AW-1:0]),
        .o_rdata (rd_a)
    );

    stwm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_item.value),
        .i_raddr (n_ib[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign accept = start && (r_state == S_IDLE);

    // Exhaustion is tracked by pointer against count, never by a sentinel value.
    assign has_a   = (r_ia < r_cnt_a);
    assign has_b   = (r_ib < r_cnt_b);
    // Take A on ties
    assign take_a  = has_a && (!has_b || ($signed(rd_a) <= $signed(rd_b)));
    assign pick    = take_a ? rd_a : rd_b;
    assign total   = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign taken   = {1'b0, r_ia} + {1'b0, r_ib} + {{CW{1'b0}}, 1'b1};
    assign is_last = (taken == total);

    assign we_a = accept && (t_op'(i_item.op) == OP_LOAD_A) && (r_cnt_a < CW'(DEPTH));
    assign we_b = accept && (t_op'(i_item.op) == OP_LOAD_B) && (r_cnt_b < CW'(DEPTH));

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_drop      = r_drop;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_res_valid = 1'b0;
        n_res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_item.op))
                        OP_LOAD_A: begin
                            // Append, or drop and flag when full
                            if (we_a) begin
                                n_cnt_a = r_cnt_a + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_LOAD_B: begin
                            if (we_b) begin
                                n_cnt_b = r_cnt_b + CW'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            // Point both heads at entry 0; empty run just clears
                            n_ia = '0;
                            n_ib = '0;
                            if (total == '0) begin
                                n_drop = 1'b0;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            // Ignore the unused op code
                        end
                    endcase
                end
            end
            S_EMIT: begin
                // Emit the smaller head and advance its pointer
                n_res_valid     = 1'b1;
                n_res.value_res = pick;
                n_res.last      = is_last;
                n_res.overflow  = r_drop;
                if (take_a) begin
                    n_ia = r_ia + CW'(1);
                end else begin
                    n_ib = r_ib + CW'(1);
                end
                if (is_last) begin
                    n_state = S_IDLE;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_drop      <= 1'b0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_drop      <= n_drop;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign busy        = (r_state == S_EMIT);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // A result only follows a cycle of merging
    a_res_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(r_state == S_EMIT))
        else $error("result shown without a merge step");

    // Head pointers never run past their fill counts while merging
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_ia <= r_cnt_a) && (r_ib <= r_cnt_b)
                                && (has_a || has_b))
        else $error("merge pointer out of range");

    // The last result of a run ends the merge and finds the runs emptied
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy && (r_cnt_a == '0) && (r_cnt_b == '0)
                                       && !r_drop)
        else $error("run state not cleared after last result");

    // While merging, a result is produced every cycle
    a_emit_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> o_res_valid)
        else $error("merge step produced no result");

endmodule
